// ===== hw/rtl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the non-overlapping pattern counter.
// ----------------------------------------------------------------------------
package npc_pkg;

   localparam int TEXT_BYTE_WIDTH = 8;
   localparam int ANSWER_WIDTH    = 14;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int LENGTH_WIDTH    = 4;
   localparam int BLOCK_WIDTH     = 3;

   localparam logic [TEXT_BYTE_WIDTH-1:0] DIGIT_LOW  = 8'h30;
   localparam logic [TEXT_BYTE_WIDTH-1:0] DIGIT_HIGH = 8'h39;
   localparam logic [ANSWER_WIDTH-1:0]    DIGIT_ANSWER = '1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN_BYTES  = 1'b0,
      CSR_PATTERN_LENGTH = 1'b1
   } npc_csr_type;

   typedef struct packed {
      logic                   match;
      logic                   digit;
      logic                   last;
      logic [BLOCK_WIDTH-1:0] hold;
   } npc_entry_type;

endpackage

// ===== hw/rtl/npc_if.sv =====
// ----------------------------------------------------------------------------
// npc_req_if / npc_rsp_if
// Valid/ready channels for text bytes and for answers.
// ----------------------------------------------------------------------------
interface npc_req_if;
   import npc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [TEXT_BYTE_WIDTH-1:0] text_byte;
   logic                       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface npc_rsp_if;
   import npc_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [ANSWER_WIDTH-1:0] answer;

   modport source (output valid, output answer, input ready);
   modport sink (input valid, input answer, output ready);
endinterface

// ===== hw/rtl/npc_front.sv =====
// ----------------------------------------------------------------------------
// npc_front
// Takes text bytes, keeps the byte window and classifies each byte as a
// pattern end and as a digit.
// ----------------------------------------------------------------------------
module npc_front #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   npc_req_if.sink                                req_chan,
   input  logic [npc_pkg::CSR_DATA_WIDTH-1:0]     pattern_bytes,
   input  logic [npc_pkg::LENGTH_WIDTH-1:0]       pattern_length,
   input  logic                                   queue_full,
   output logic                                   push,
   output npc_pkg::npc_entry_type                 push_entry
);
   import npc_pkg::*;

   localparam int WIN_WIDTH  = TEXT_BYTE_WIDTH * MAX_PATTERN;
   localparam int SEEN_WIDTH = $clog2(MAX_PATTERN + 1);
   localparam int IDX_WIDTH  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [WIN_WIDTH-1:0]  window_ff, window_in;
   logic [SEEN_WIDTH-1:0] seen_ff, seen_in, seen_next;
   logic [SEEN_WIDTH-1:0] used_len;
   logic [WIN_WIDTH-1:0]  window_next;
   logic [MAX_PATTERN-1:0] len_ok;
   logic                  accept;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;

   always_comb begin
      if (pattern_length == '0) begin
         used_len = SEEN_WIDTH'(1);
      end else if (pattern_length > LENGTH_WIDTH'(MAX_PATTERN)) begin
         used_len = SEEN_WIDTH'(MAX_PATTERN);
      end else begin
         used_len = SEEN_WIDTH'(pattern_length);
      end
   end

   generate
      if (MAX_PATTERN > 1) begin : g_shift
         assign window_next = {window_ff[WIN_WIDTH-TEXT_BYTE_WIDTH-1:0], req_chan.text_byte};
      end else begin : g_single
         assign window_next = req_chan.text_byte;
      end
   endgenerate

   assign seen_next = (seen_ff < SEEN_WIDTH'(MAX_PATTERN)) ? seen_ff + 1'b1 : seen_ff;

   always_comb begin
      for (int l = 0; l < MAX_PATTERN; l++) begin
         len_ok[l] = 1'b1;
         for (int i = 0; i <= l; i++) begin
            if (window_next[(l-i)*TEXT_BYTE_WIDTH +: TEXT_BYTE_WIDTH] !=
                pattern_bytes[i*TEXT_BYTE_WIDTH +: TEXT_BYTE_WIDTH]) begin
               len_ok[l] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      push_entry.match = (seen_next >= used_len) &&
                         len_ok[IDX_WIDTH'(used_len - 1'b1)];
      push_entry.digit = (req_chan.text_byte >= DIGIT_LOW) &&
                         (req_chan.text_byte <= DIGIT_HIGH);
      push_entry.last  = req_chan.end_of_text;
      push_entry.hold  = BLOCK_WIDTH'(used_len - 1'b1);
      push             = accept;
   end

   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      if (accept) begin
         if (req_chan.end_of_text) begin
            window_in = '0;
            seen_in   = '0;
         end else begin
            window_in = window_next;
            seen_in   = seen_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= '0;
      end else begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

// ===== hw/rtl/npc_queue.sv =====
// ----------------------------------------------------------------------------
// npc_queue
// Two-entry queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module npc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  npc_pkg::npc_entry_type push_entry,
   input  logic                   pop,
   output npc_pkg::npc_entry_type pop_entry,
   output logic                   full,
   output logic                   empty
);
   import npc_pkg::*;

   npc_entry_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/npc_back.sv =====
// ----------------------------------------------------------------------------
// npc_back
// Applies the match blocking, counts matches, tracks digits and holds the
// answer of each text in an output register.
// ----------------------------------------------------------------------------
module npc_back #(
   parameter int MAX_TEXT_LEN = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  npc_pkg::npc_entry_type pop_entry,
   output logic                   pop,
   npc_rsp_if.source              rsp_chan
);
   import npc_pkg::*;

   localparam int COUNT_WIDTH = $clog2(MAX_TEXT_LEN + 1);

   logic [COUNT_WIDTH-1:0]  total_ff, total_in;
   logic [BLOCK_WIDTH-1:0]  blocked_ff, blocked_in;
   logic                    digit_ff, digit_in;
   logic                    valid_ff, valid_in;
   logic [ANSWER_WIDTH-1:0] answer_ff, answer_in;

   assign pop             = !empty && (!valid_ff || rsp_chan.ready);
   assign rsp_chan.valid  = valid_ff;
   assign rsp_chan.answer = answer_ff;

   always_comb begin
      total_in   = total_ff;
      blocked_in = blocked_ff;
      digit_in   = digit_ff;
      valid_in   = valid_ff && !rsp_chan.ready;
      answer_in  = answer_ff;
      if (pop) begin
         digit_in = digit_ff || pop_entry.digit;
         if (blocked_ff != '0) begin
            blocked_in = blocked_ff - 1'b1;
         end else if (pop_entry.match) begin
            if (total_ff < COUNT_WIDTH'(MAX_TEXT_LEN)) begin
               total_in = total_ff + 1'b1;
            end
            blocked_in = pop_entry.hold;
         end
         if (pop_entry.last) begin
            valid_in   = 1'b1;
            answer_in  = digit_in ? DIGIT_ANSWER : ANSWER_WIDTH'(total_in);
            total_in   = '0;
            blocked_in = '0;
            digit_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      answer_ff <= answer_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         blocked_ff <= '0;
         digit_ff   <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         total_ff   <= total_in;
         blocked_ff <= blocked_in;
         digit_ff   <= digit_in;
         valid_ff   <= valid_in;
      end
   end

endmodule

// ===== hw/rtl/nonoverlap_pattern_counter.sv =====
// The last text byte passes through a queue slot and then into the answer register before the answer is valid.
// Throughput: one byte per cycle when the queue has room; the compare is in the transfer cycle.
// A two-entry queue lets the byte intake and the counting stall independently.
// Reset is synchronous and active high; it clears the text state except the answer and queue
// data registers, sets the pattern to zero and the pattern length to one.
// ----------------------------------------------------------------------------
// nonoverlap_pattern_counter
// Counts non-overlapping occurrences of a pattern of up to eight bytes in a
// byte stream and reports the count, or -1 for a text with digits.
// ----------------------------------------------------------------------------
module nonoverlap_pattern_counter #(
   parameter int MAX_PATTERN  = 8,
   parameter int MAX_TEXT_LEN = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   npc_req_if.sink                             req_chan,
   npc_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [npc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [npc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import npc_pkg::*;

   logic [CSR_DATA_WIDTH-1:0] pattern_bytes_ff, pattern_bytes_in;
   logic [LENGTH_WIDTH-1:0]   pattern_length_ff, pattern_length_in;
   logic                      push, pop, full, empty;
   npc_entry_type             push_entry, pop_entry;

   always_comb begin
      pattern_bytes_in  = pattern_bytes_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_write_enable) begin
         case (npc_csr_type'(csr_index))
            CSR_PATTERN_BYTES: begin
               pattern_bytes_in = csr_write_data;
            end
            CSR_PATTERN_LENGTH: begin
               pattern_length_in = csr_write_data[LENGTH_WIDTH-1:0];
            end
            default: begin
               pattern_bytes_in = pattern_bytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= LENGTH_WIDTH'(1);
      end else begin
         pattern_bytes_ff  <= pattern_bytes_in;
         pattern_length_ff <= pattern_length_in;
      end
   end

   npc_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .pattern_bytes  (pattern_bytes_ff),
      .pattern_length (pattern_length_ff),
      .queue_full     (full),
      .push           (push),
      .push_entry     (push_entry)
   );

   npc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (full),
      .empty      (empty)
   );

   npc_back #(
      .MAX_TEXT_LEN (MAX_TEXT_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
